// ----- src/assert_macros.svh -----
// assertion macros shared by the rtl, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RPE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rope assertion failed");

// next-cycle implication
`define RPE_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rope assertion failed");

`endif

// ----- src/rpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rpe_pkg
// Constants, tables and register codes of the rotary position embedding.
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int MAX_HEAD_DIM_DEF  = 256;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX_STAGES = 24;
  localparam int DIV_BITS          = 32;
  localparam int EXP_TERMS         = 14;

  localparam int HEAD_DIM_W   = 9;
  localparam int LOG2_THETA_W = 24;
  localparam int CFG_DATA_W   = 24;
  localparam int CFG_INDEX_W  = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAD_DIM   = 1'b0,
    REG_LOG2_THETA = 1'b1
  } reg_index_t;

  localparam logic [HEAD_DIM_W-1:0]   HEAD_DIM_RST   = 9'd128;
  localparam logic [LOG2_THETA_W-1:0] LOG2_THETA_RST = 24'd870813;

  localparam longint LN2_Q32      = 64'd2977044472;
  localparam longint TWO_PI_Q32   = 64'd26986075409;
  localparam longint PI_Q32       = 64'd13493037705;
  localparam longint HALF_PI_Q32  = 64'd6746518852;
  localparam longint CORDIC_K_Q32 = 64'd2608131496;

  // reciprocal for the reduction by two pi, scaled by 2^56
  localparam longint TWO_PI_RECIP = (64'd1 << 56) / TWO_PI_Q32;

  // floor(2^32 / n) for the series divisors
  localparam logic [31:0] RECIP_Q32 [EXP_TERMS+1] = '{
    32'd0, 32'd0, 32'd2147483648, 32'd1431655765, 32'd1073741824,
    32'd858993459, 32'd715827882, 32'd613566756, 32'd536870912,
    32'd477218588, 32'd429496729, 32'd390451572, 32'd357913941,
    32'd330382099, 32'd306783378
  };

  // atan(2^-i) in q.32
  localparam logic [31:0] ATAN_Q32 [CORDIC_MAX_STAGES] = '{
    32'd3373259426, 32'd1991351316, 32'd1052175345, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553750,
    32'd16777131,   32'd8388598,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512
  };

endpackage

// ----- src/rotary_position_embedding_top.sv -----
// ----------------------------------------------------------------------------
// rotary_position_embedding_top
// Half-split rotary position embedding of one component pair per request.
// ----------------------------------------------------------------------------
// Input channel: valid / stall carries position, pair_index, first_value,
// second_value and end_of_tensor; a request is taken when valid is high and
// stall is low. Output channel: result_valid / result_stall carries
// first_rotated, second_rotated and end_flag, one result per request.
// Configuration: cfg_write with cfg_index and cfg_data writes head_size
// (index 0) or log2_theta (index 1); the user must write them only while
// the block is empty, and the block itself does not enforce this. A result
// passes through 84 + CORDIC_STAGES register stages: an input register, 32
// divider stages, 42 exponent stages, 6 angle reduction stages, the cordic
// stages and 3 rotation stages. One request is taken every cycle while
// stall is low.
// Reset empties the pipeline and loads head_size 128 and log2_theta 870813.
// While result_stall holds back a waiting result the whole pipeline freezes
// and stall is raised towards the sender; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_position_embedding_top
  import rpe_pkg::*;
#(
  parameter int MAX_HEAD_DIM  = MAX_HEAD_DIM_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   valid,
  output logic                   stall,
  input  logic [19:0]            position,
  input  logic [6:0]             pair_index,
  input  logic signed [15:0]     first_value,
  input  logic signed [15:0]     second_value,
  input  logic                   end_of_tensor,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic signed [15:0]     first_rotated,
  output logic signed [15:0]     second_rotated,
  output logic                   end_flag
);

  localparam int S_EXP0   = DIV_BITS + 1;
  localparam int S_EXP1   = S_EXP0 + 1;
  localparam int S_TERM   = S_EXP1 + 1;
  localparam int S_W      = S_TERM + 3 * (EXP_TERMS - 1);
  localparam int S_ANG    = S_W + 1;
  localparam int S_QP     = S_ANG + 1;
  localparam int S_QC     = S_QP + 1;
  localparam int S_RED    = S_QC + 1;
  localparam int S_WRAP   = S_RED + 1;
  localparam int S_FOLD   = S_WRAP + 1;
  localparam int S_CORDIC = S_FOLD + 1;
  localparam int S_MUL    = S_CORDIC + CORDIC_STAGES;
  localparam int S_SUM    = S_MUL + 1;
  localparam int LAST     = S_SUM + 1;

  localparam logic [33:0]        SUM_LO    = 34'h080000000;
  localparam logic [33:0]        SUM_HI    = 34'h100000000;
  localparam logic signed [36:0] HALF_PI_Z = 37'(HALF_PI_Q32);

  typedef struct packed {
    logic [19:0]        pos;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               eot;
    logic [31:0]        n;
    logic [8:0]         rem;
    logic [15:0]        ei;
    logic [31:0]        y;
    logic [31:0]        term;
    logic [63:0]        prod;
    logic [31:0]        quo;
    logic [33:0]        sum;
    logic [32:0]        w;
    logic [52:0]        angle;
    logic [53:0]        qp;
    logic [54:0]        qc;
    logic [35:0]        r;
    logic signed [36:0] z;
    logic               neg;
    logic signed [35:0] cx;
    logic signed [35:0] cy;
    logic signed [52:0] p0;
    logic signed [52:0] p1;
    logic signed [52:0] p2;
    logic signed [52:0] p3;
    logic signed [53:0] s1;
    logic signed [53:0] s2;
    logic signed [15:0] o1;
    logic signed [15:0] o2;
  } stage_t;

  logic [HEAD_DIM_W-1:0]   head_size;
  logic [LOG2_THETA_W-1:0] log2_theta;
  logic [HEAD_DIM_W-1:0]   hd_c;
  logic                    adv;
  logic [LAST:0]           vld;
  stage_t                  pipe      [LAST+1];
  stage_t                  pipe_next [LAST+1];

  function automatic stage_t div_step(stage_t p, logic [HEAD_DIM_W-1:0] hd);
    stage_t    o;
    logic [9:0] rs;
    logic       qb;
    o  = p;
    rs = {p.rem, p.n[31]};
    qb = (rs >= {1'b0, hd});
    o.rem = qb ? 9'(rs - {1'b0, hd}) : rs[8:0];
    o.n   = {p.n[30:0], qb};
    return o;
  endfunction

  function automatic stage_t term_recip(stage_t p, int n);
    stage_t o;
    o = p;
    o.quo = 32'((64'(p.prod[63:32]) * 64'(RECIP_Q32[4'(n)])) >> 32);
    return o;
  endfunction

  function automatic stage_t term_fix(stage_t p, int n);
    stage_t      o;
    logic [35:0] rr;
    logic [31:0] q;
    o  = p;
    rr = 36'(p.prod[63:32]) - 36'(p.quo) * 36'(n);
    q  = (rr >= 36'(n)) ? p.quo + 32'd1 : p.quo;
    o.term = q;
    o.sum  = ((n & 1) == 1) ? p.sum - 34'(q) : p.sum + 34'(q);
    return o;
  endfunction

  function automatic stage_t cordic_step(stage_t p, int i);
    stage_t             o;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    logic signed [36:0] t;
    o  = p;
    xs = p.cx >>> i;
    ys = p.cy >>> i;
    t  = signed'({5'b0, ATAN_Q32[5'(i)]});
    if (p.z >= 0) begin
      o.cx = p.cx - ys;
      o.cy = p.cy + xs;
      o.z  = p.z - t;
    end else begin
      o.cx = p.cx + ys;
      o.cy = p.cy - xs;
      o.z  = p.z + t;
    end
    return o;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [53:0] s);
    logic signed [21:0] t;
    t = 22'(s >>> 32);
    if (t > 22'sd32767) begin
      return 16'sh7fff;
    end else if (t < -22'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_size  <= HEAD_DIM_RST;
      log2_theta <= LOG2_THETA_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_HEAD_DIM:   head_size  <= cfg_data[HEAD_DIM_W-1:0];
        REG_LOG2_THETA: log2_theta <= cfg_data[LOG2_THETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (head_size < 9'd2) begin
      hd_c = 9'd2;
    end else if (int'(head_size) > MAX_HEAD_DIM) begin
      hd_c = HEAD_DIM_W'(MAX_HEAD_DIM);
    end else begin
      hd_c = head_size;
    end
  end

  assign adv   = !(vld[LAST] && result_stall);
  assign stall = !adv;

  always_comb begin
    stage_t             t;
    logic signed [36:0] xf;
    logic signed [36:0] yf;
    logic [55:0]        rr;
    logic [35:0]        rc;

    t       = '0;
    t.pos   = position;
    t.a     = first_value;
    t.b     = second_value;
    t.eot   = end_of_tensor;
    t.n     = 32'(log2_theta) * 32'({pair_index, 1'b0});
    t.rem   = '0;
    pipe_next[0] = t;

    for (int d = 1; d <= DIV_BITS; d++) begin
      pipe_next[d] = div_step(pipe[d-1], hd_c);
    end

    // fraction of the exponent times ln 2
    t      = pipe[S_EXP0-1];
    t.ei   = t.n[31:16];
    t.y    = 32'((48'(t.n[15:0]) * 48'(LN2_Q32)) >> 16);
    pipe_next[S_EXP0] = t;

    t      = pipe[S_EXP1-1];
    t.term = t.y;
    t.sum  = 34'h100000000 - 34'(t.y);
    pipe_next[S_EXP1] = t;

    for (int n = 2; n <= EXP_TERMS; n++) begin
      t      = pipe[S_TERM+3*(n-2)-1];
      t.prod = 64'(t.term) * 64'(t.y);
      pipe_next[S_TERM+3*(n-2)]   = t;
      pipe_next[S_TERM+3*(n-2)+1] = term_recip(pipe[S_TERM+3*(n-2)], n);
      pipe_next[S_TERM+3*(n-2)+2] = term_fix(pipe[S_TERM+3*(n-2)+1], n);
    end

    t   = pipe[S_W-1];
    t.w = (t.ei > 16'd40) ? '0 : 33'(t.sum[32:0] >> t.ei);
    pipe_next[S_W] = t;

    t       = pipe[S_ANG-1];
    t.angle = 53'(t.pos) * 53'(t.w);
    pipe_next[S_ANG] = t;

    // angle modulo two pi
    t     = pipe[S_QP-1];
    t.qp  = 54'(t.angle[52:21]) * 54'(TWO_PI_RECIP);
    pipe_next[S_QP] = t;

    t     = pipe[S_QC-1];
    t.quo = 32'(t.qp >> 35);
    t.qc  = 55'(t.quo[19:0]) * 55'(TWO_PI_Q32);
    pipe_next[S_QC] = t;

    t  = pipe[S_RED-1];
    rr = 56'(t.angle) - 56'(t.qc);
    rc = rr[35:0];
    t.r = (rc >= 36'(TWO_PI_Q32)) ? rc - 36'(TWO_PI_Q32) : rc;
    pipe_next[S_RED] = t;

    t   = pipe[S_WRAP-1];
    t.z = (t.r > 36'(PI_Q32)) ? signed'({1'b0, t.r}) - 37'(TWO_PI_Q32)
                               : signed'({1'b0, t.r});
    pipe_next[S_WRAP] = t;

    // fold into the right half plane
    t     = pipe[S_FOLD-1];
    t.neg = 1'b0;
    if (t.z > 37'(HALF_PI_Q32)) begin
      t.z   = t.z - 37'(PI_Q32);
      t.neg = 1'b1;
    end else if (t.z < -37'(HALF_PI_Q32)) begin
      t.z   = t.z + 37'(PI_Q32);
      t.neg = 1'b1;
    end
    t.cx = 36'(CORDIC_K_Q32);
    t.cy = '0;
    pipe_next[S_FOLD] = t;

    for (int i = 0; i < CORDIC_STAGES; i++) begin
      pipe_next[S_CORDIC+i] = cordic_step(pipe[S_CORDIC+i-1], i);
    end

    t  = pipe[S_MUL-1];
    xf = t.neg ? -37'(t.cx) : 37'(t.cx);
    yf = t.neg ? -37'(t.cy) : 37'(t.cy);
    t.p0 = 53'(t.a) * 53'(xf);
    t.p1 = 53'(t.b) * 53'(yf);
    t.p2 = 53'(t.b) * 53'(xf);
    t.p3 = 53'(t.a) * 53'(yf);
    pipe_next[S_MUL] = t;

    t    = pipe[S_SUM-1];
    t.s1 = 54'(t.p0) - 54'(t.p1) + 54'sh80000000;
    t.s2 = 54'(t.p2) + 54'(t.p3) + 54'sh80000000;
    pipe_next[S_SUM] = t;

    t    = pipe[LAST-1];
    t.o1 = sat16(t.s1);
    t.o2 = sat16(t.s2);
    pipe_next[LAST] = t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe <= pipe_next;
    end
  end

  assign result_valid   = vld[LAST];
  assign first_rotated  = pipe[LAST].o1;
  assign second_rotated = pipe[LAST].o2;
  assign end_flag       = pipe[LAST].eot;

  `RPE_ASSERT_NEXT(a_accept_enters, valid && !stall, vld[0])
  `RPE_ASSERT_IMP(a_div_rem, vld[DIV_BITS], pipe[DIV_BITS].rem < hd_c)
  `RPE_ASSERT_IMP(a_exp_range, vld[S_W-1], (pipe[S_W-1].sum >= SUM_LO) && (pipe[S_W-1].sum <= SUM_HI))
  `RPE_ASSERT_IMP(a_fold_range, vld[S_FOLD], (pipe[S_FOLD].z <= HALF_PI_Z) && (pipe[S_FOLD].z >= -HALF_PI_Z))

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotary_position_embedding_top. Requests are driven
// with random gaps and output stalls over several head size / log2_theta
// values; a scoreboard predicts each rotated pair in 64-bit fixed point and
// compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
  import rpe_pkg::*;
();

  typedef struct packed {
    logic signed [15:0] first_rotated;
    logic signed [15:0] second_rotated;
    logic               end_flag;
  } rotated_t;

  class rope_scoreboard;
    longint unsigned head_size = HEAD_DIM_RST;
    longint unsigned log2_theta = LOG2_THETA_RST;
    rotated_t pending[$];
    int errors = 0;

    function longint atan_angle(int i);
      longint sum = 0;
      longint unsigned p;
      int k = 0;
      if (i == 0) return 64'd3373259426;
      if (i >= 32) return 0;
      p = 64'd1 << (32 - i);
      while (p != 0) begin
        sum += (k % 2) ? -longint'(p / (2 * k + 1)) : longint'(p / (2 * k + 1));
        k++;
        p = (2 * i < 64) ? (p >> (2 * i)) : 0;
      end
      return sum;
    endfunction

    function logic signed [15:0] round_sat(longint v);
      longint r = (v + (longint'(1) <<< 31)) >>> 32;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_request(logic [19:0] pos, logic [6:0] j,
                               logic signed [15:0] a, logic signed [15:0] b,
                               logic eot);
      longint unsigned hd, e, ei, y, s, term, w, angle;
      longint z, x, yy, xs, ys, t;
      bit neg = 0;
      rotated_t r;
      hd = head_size;
      if (hd < 2) hd = 2;
      if (hd > MAX_HEAD_DIM_DEF) hd = MAX_HEAD_DIM_DEF;
      e = (log2_theta * 2 * longint'(j)) / hd;
      ei = e >> 16;
      y = ((e & 64'hFFFF) * longint'(LN2_Q32)) >> 16;
      s = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int n = 1; n <= EXP_TERMS; n++) begin
        term = ((term * y) >> 32) / n;
        if (n % 2) s -= term;
        else s += term;
      end
      w = (ei > 40) ? 0 : (s >> ei);
      angle = longint'(pos) * w;
      z = longint'(angle % longint'(TWO_PI_Q32));
      if (z > PI_Q32) z -= TWO_PI_Q32;
      if (z > HALF_PI_Q32) begin
        z -= PI_Q32;
        neg = 1;
      end else if (z < -HALF_PI_Q32) begin
        z += PI_Q32;
        neg = 1;
      end
      x = CORDIC_K_Q32;
      yy = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        xs = x >>> i;
        ys = yy >>> i;
        t = atan_angle(i);
        if (z >= 0) begin
          x -= ys; yy += xs; z -= t;
        end else begin
          x += ys; yy -= xs; z += t;
        end
      end
      if (neg) begin
        x = -x;
        yy = -yy;
      end
      r.first_rotated = round_sat(longint'(a) * x - longint'(b) * yy);
      r.second_rotated = round_sat(longint'(b) * x + longint'(a) * yy);
      r.end_flag = eot;
      pending.push_back(r);
    endfunction

    function void check_result(rotated_t got);
      rotated_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.first_rotated !== want.first_rotated) begin
        $display("%0t: first_rotated expected %0d got %0d", $time,
                 want.first_rotated, got.first_rotated);
        errors++;
      end
      if (got.second_rotated !== want.second_rotated) begin
        $display("%0t: second_rotated expected %0d got %0d", $time,
                 want.second_rotated, got.second_rotated);
        errors++;
      end
      if (got.end_flag !== want.end_flag) begin
        $display("%0t: end_flag expected %0d got %0d", $time,
                 want.end_flag, got.end_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_HEAD_DIM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic valid = 0, stall;
  logic [19:0] position = '0;
  logic [6:0] pair_index = '0;
  logic signed [15:0] first_value = '0, second_value = '0;
  logic end_of_tensor = 0;
  logic result_valid, result_stall = 0;
  logic signed [15:0] first_rotated, second_rotated;
  logic end_flag;

  rope_scoreboard rope_sb = new();
  bit hold_off_req = 0;
  bit steady = 0;

  rotary_position_embedding_top dut (.*);

  initial forever #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("** rotary_position_embedding_top: FAILED **");
    $finish;
  end

  always @(posedge clk)
    if (!rst && result_valid && !result_stall)
      rope_sb.check_result('{first_rotated, second_rotated, end_flag});

  // output side: random stalls, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        result_stall = 1;
        repeat (300) @(negedge clk);
        hold_off_req = 0;
      end
      n = steady ? 0 : $urandom_range(0, 4);
      result_stall = (n > 0);
      repeat (n) @(negedge clk);
      result_stall = 0;
      do @(posedge clk); while (!result_valid);
    end
  end

  task automatic send_request(logic [19:0] pos, logic [6:0] j,
                              logic [15:0] a, logic [15:0] b, logic eot);
    int gap;
    @(negedge clk);
    valid = 1;
    position = pos;
    pair_index = j;
    first_value = a;
    second_value = b;
    end_of_tensor = eot;
    do @(posedge clk); while (stall);
    rope_sb.note_request(pos, j, a, b, eot);
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk);
      valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random();
    logic [19:0] pos;
    pos = ($urandom_range(0, 1)) ? 20'($urandom) : 20'($urandom_range(0, 64));
    send_request(pos, 7'($urandom), 16'($urandom), 16'($urandom),
                 $urandom_range(0, 15) == 0);
  endtask

  task automatic drain();
    @(negedge clk);
    valid = 0;
    while (rope_sb.pending.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1;
    cfg_index = idx;
    cfg_data = data;
    if (idx == REG_HEAD_DIM) rope_sb.head_size = data & 24'h1FF;
    else rope_sb.log2_theta = data;
    @(negedge clk);
    cfg_write = 0;
  endtask

  initial begin
    int hd_set[7] = '{128, 2, 256, 0, 511, 3, 64};
    int lt_set[7] = '{870813, 0, 16777215, 870813, 16777215, 65536, 1000000};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: field extremes, big angles, tiny frequency, saturation
    send_request(0, 0, 16'h7FFF, 16'h8000, 0);
    send_request(20'hFFFFF, 0, 16'h7FFF, 16'h7FFF, 0);
    send_request(20'hFFFFF, 127, 16'h8000, 16'h8000, 1);
    send_request(1, 1, 16'h1000, 16'h0000, 0);
    send_request(2, 1, 16'h0000, 16'h1000, 0);
    send_request(3, 0, 16'h1000, 16'h1000, 0);
    send_request(20'hFFFFF, 64, 16'h7FFF, 16'h8000, 0);
    send_request(12345, 63, 16'hFFFF, 16'h0001, 1);
    send_request(20'h55555, 7'h55, 16'h5555, 16'hAAAA, 0);
    send_request(20'hAAAAA, 7'h2A, 16'hAAAA, 16'h5555, 1);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(REG_HEAD_DIM, 24'(hd_set[ph]));
        write_reg(REG_LOG2_THETA, 24'(lt_set[ph]));
      end
      steady = (ph == 3);
      if (ph == 1) hold_off_req = 1;
      for (int k = 0; k < 85; k++) send_random();
      send_request(20'hFFFFF, 127, 16'h8000, 16'h7FFF, 1);
      drain();
    end
    write_reg(REG_HEAD_DIM, 24'($urandom_range(2, 256)));
    write_reg(REG_LOG2_THETA, 24'($urandom));
    for (int k = 0; k < 20; k++) send_random();
    drain();

    if (rope_sb.errors == 0 && rope_sb.pending.size() == 0)
      $display("** rotary_position_embedding_top: PASSED **");
    else
      $display("** rotary_position_embedding_top: FAILED **");
    $finish;
  end
endmodule
